@@ design/hcipd_pkg.sv @@
// shared types and constants for the hci packet deframer
// no dependencies; compiled before the interfaces and modules
package hcipd_pkg;

  // hard ceiling on the accepted payload length
  localparam logic [7:0] MAX_PAYLOAD_LIMIT = 8'd240;

  // register reset values
  localparam logic [7:0] SYNC_BYTE_RST   = 8'd25;
  localparam logic [7:0] MAX_PAYLOAD_RST = 8'd240;

  // register index decoded from paddr bit 2
  localparam logic REG_SYNC_BYTE   = 1'b0;
  localparam logic REG_MAX_PAYLOAD = 1'b1;

  // parser states
  typedef enum logic [2:0] {
    ST_HUNT    = 3'd0,
    ST_OP_LO   = 3'd1,
    ST_OP_HI   = 3'd2,
    ST_LEN_LO  = 3'd3,
    ST_LEN_HI  = 3'd4,
    ST_PAYLOAD = 3'd5
  } hcipd_state_e;

  // configuration seen by the parser
  typedef struct packed {
    logic [7:0] sync_byte;
    logic [7:0] max_payload;
  } hcipd_cfg_t;

  // one result transaction
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic        last_byte;
    logic [15:0] packet_opcode;
    logic [15:0] packet_length;
    logic        header_rejected;
    logic        sync_error_seen;
  } hcipd_result_t;

endpackage

@@ design/hcipd_if.sv @@
// valid/ready stream interfaces for the deframer input bytes and results
// no dependencies
interface hcipd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface hcipd_out_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_index;
  logic        last_byte;
  logic [15:0] packet_opcode;
  logic [15:0] packet_length;
  logic        header_rejected;
  logic        sync_error_seen;

  modport source (
    output valid, input ready,
    output payload_valid, output payload_byte, output payload_index, output last_byte,
    output packet_opcode, output packet_length, output header_rejected,
    output sync_error_seen
  );
  modport sink (
    input valid, output ready,
    input payload_valid, input payload_byte, input payload_index, input last_byte,
    input packet_opcode, input packet_length, input header_rejected,
    input sync_error_seen
  );
endinterface

@@ design/hcipd_parser.sv @@
// per-byte frame parser: state machine, header registers and payload counter
// depends on hcipd_pkg
module hcipd_parser (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic [7:0]              data_byte_i,
  input  hcipd_pkg::hcipd_cfg_t   cfg_i,
  output hcipd_pkg::hcipd_result_t result_o
);
  import hcipd_pkg::*;

  hcipd_state_e state_q, state_d;
  logic [15:0]  opcode_q, opcode_d;
  logic [15:0]  length_q, length_d;
  logic [7:0]   count_q, count_d;
  logic         sync_err_q, sync_err_d;

  logic [7:0]   eff_max;
  logic [15:0]  len_new;
  logic [7:0]   count_inc;

  // saturate the configured maximum and form the candidate values
  assign eff_max   = (cfg_i.max_payload > MAX_PAYLOAD_LIMIT) ? MAX_PAYLOAD_LIMIT
                                                             : cfg_i.max_payload;
  assign len_new   = {data_byte_i, length_q[7:0]};
  assign count_inc = count_q + 8'd1;

  // next state and result for the current byte
  always_comb begin
    state_d    = state_q;
    opcode_d   = opcode_q;
    length_d   = length_q;
    count_d    = count_q;
    sync_err_d = sync_err_q;

    result_o.payload_valid   = 1'b0;
    result_o.payload_byte    = 8'h00;
    result_o.payload_index   = 8'h00;
    result_o.last_byte       = 1'b0;
    result_o.header_rejected = 1'b0;

    case (state_q)
      ST_HUNT: begin
        if (data_byte_i == cfg_i.sync_byte) begin
          opcode_d = 16'h0000;
          length_d = 16'h0000;
          count_d  = 8'h00;
          state_d  = ST_OP_LO;
        end else begin
          sync_err_d = 1'b1;
        end
      end
      ST_OP_LO: begin
        opcode_d = {8'h00, data_byte_i};
        state_d  = ST_OP_HI;
      end
      ST_OP_HI: begin
        opcode_d = {data_byte_i, opcode_q[7:0]};
        state_d  = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        length_d = {8'h00, data_byte_i};
        state_d  = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        length_d = len_new;
        if ((len_new != 16'h0000) && (len_new <= {8'h00, eff_max})) begin
          state_d = ST_PAYLOAD;
        end else begin
          result_o.header_rejected = 1'b1;
          state_d                  = ST_HUNT;
        end
      end
      ST_PAYLOAD: begin
        result_o.payload_valid = 1'b1;
        result_o.payload_byte  = data_byte_i;
        result_o.payload_index = count_q;
        count_d                = count_inc;
        if ({8'h00, count_inc} >= length_q) begin
          result_o.last_byte = 1'b1;
          state_d            = ST_HUNT;
        end
      end
      default: begin
        state_d = ST_HUNT;
      end
    endcase

    result_o.packet_opcode   = opcode_d;
    result_o.packet_length   = length_d;
    result_o.sync_error_seen = sync_err_d;
  end

  // parser registers advance once per accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_HUNT;
      opcode_q   <= 16'h0000;
      length_q   <= 16'h0000;
      count_q    <= 8'h00;
      sync_err_q <= 1'b0;
    end else if (step_i) begin
      state_q    <= state_d;
      opcode_q   <= opcode_d;
      length_q   <= length_d;
      count_q    <= count_d;
      sync_err_q <= sync_err_d;
    end
  end

endmodule

@@ design/hci_packet_deframer.sv @@
// hci packet deframer top level: apb registers, parser and result register
// result: registered, valid in the cycle after its byte is accepted
// throughput: one byte per cycle unless the output stalls; the result register takes a new result
//   in the same cycle that the previous one is taken
// reset: asynchronous active low; parser hunts for sync, registers to defaults
// depends on hcipd_pkg, hcipd_if and hcipd_parser
module hci_packet_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  hcipd_in_if.sink    in_i,
  hcipd_out_if.source out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hcipd_pkg::*;

  logic          sel_sync;
  logic [7:0]    sync_val_q;
  logic [7:0]    max_payload_q;
  hcipd_cfg_t    cfg;
  logic          cfg_write;
  logic          step;
  hcipd_result_t result;
  hcipd_result_t out_q;
  logic          out_valid_q, out_valid_d;

  // register writes complete in the access phase
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign sel_sync  = (paddr[2] == REG_SYNC_BYTE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_val_q    <= SYNC_BYTE_RST;
      max_payload_q <= MAX_PAYLOAD_RST;
    end else if (cfg_write) begin
      if (sel_sync) begin
        sync_val_q <= pwdata[7:0];
      end else begin
        max_payload_q <= pwdata[7:0];
      end
    end
  end

  // register read back
  always_comb begin
    case (paddr[2])
      REG_SYNC_BYTE:   prdata = {24'h000000, sync_val_q};
      REG_MAX_PAYLOAD: prdata = {24'h000000, max_payload_q};
      default:         prdata = 32'h0000_0000;
    endcase
  end

  assign cfg.sync_byte   = sync_val_q;
  assign cfg.max_payload = max_payload_q;

  // accept a byte whenever the result register is free or being drained
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign step       = in_i.valid && in_i.ready;

  hcipd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (in_i.data_byte),
    .cfg_i       (cfg),
    .result_o    (result)
  );

  // result register
  assign out_valid_d = step || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.payload_valid   = out_q.payload_valid;
  assign out_o.payload_byte    = out_q.payload_byte;
  assign out_o.payload_index   = out_q.payload_index;
  assign out_o.last_byte       = out_q.last_byte;
  assign out_o.packet_opcode   = out_q.packet_opcode;
  assign out_o.packet_length   = out_q.packet_length;
  assign out_o.header_rejected = out_q.header_rejected;
  assign out_o.sync_error_seen = out_q.sync_error_seen;

endmodule
